@@ src/chkv_pkg.sv @@
// Package: types and constants for the chained hash key/value map.
`default_nettype none
package chkv_pkg;
  localparam int NUM_BUCKETS = 64;
  localparam int POOL_ENTRIES = 256;
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int LW = $clog2(POOL_ENTRIES + 1);
  localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] key;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
    logic        status;
  } out_item_t;

  typedef struct packed {
    in_item_t       item;
    logic [BW-1:0]  bucket;
  } cmd_t;
endpackage
`default_nettype wire

@@ src/chained_hash_key_value_map.sv @@
// Top level: chained hash key/value map with queue-style channels.
// Usage:
//   Items (func, key, value) enter through push/full; an item is taken at a
//   clock edge with push high and full low. A two-entry command queue holds
//   items while the back end is busy.
//   Results (found, read_value, status) leave through empty/pop; a result is
//   shown while empty is low and taken at an edge with pop high.
//   func 0 inserts or updates a key, func 1 looks it up.
// Back end:
//   Each item occupies the back end from the head read through its chain walk
//   to the done state; every chain entry passed before the key's slot costs a
//   memory read step plus a compare step. A new command is taken only when idle.
// Reset:
//   rst (synchronous) empties all buckets and the entry pool at once.
// Stall:
//   While a result waits unpopped, the back end runs its next command up to
//   the compare that ends the walk and holds there; the command queue then
//   fills and full rises.
`default_nettype none
module chained_hash_key_value_map (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire chkv_pkg::in_item_t  in_item,
  output logic                     empty,
  input  wire logic                pop,
  output chkv_pkg::out_item_t      out_item
);
  logic           cmd_valid, cmd_take;
  chkv_pkg::cmd_t cmd;

  chkv_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  chkv_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take), .empty(empty), .pop(pop), .out_item(out_item)
  );

  a_take_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid) else $error("command taken from empty queue");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("waiting result changed");
  a_lookup_status: assert property (@(posedge clk) disable iff (rst)
    !empty && out_item.status |-> !out_item.found)
    else $error("refused insert reports found");
endmodule
`default_nettype wire

@@ src/chkv_front.sv @@
// Front end: accepts items, computes the bucket and queues commands.
`default_nettype none
module chkv_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire chkv_pkg::in_item_t in_item,
  output logic                   cmd_valid,
  output chkv_pkg::cmd_t         cmd,
  input  wire logic              cmd_take
);
  chkv_pkg::cmd_t q [2];
  logic [1:0] count;
  logic       wp, rp;
  logic       do_push, do_pop;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rp];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp].item   <= in_item;
      q[wp].bucket <= in_item.key[chkv_pkg::BW-1:0] & chkv_pkg::BW'(chkv_pkg::NUM_BUCKETS - 1);
    end
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (do_push) wp <= !wp;
      if (do_pop) rp <= !rp;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule
`default_nettype wire

@@ src/chkv_back.sv @@
// Back end: walks the bucket chain in memory and performs insert or lookup.
`default_nettype none
module chkv_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  input  wire chkv_pkg::cmd_t     cmd,
  output logic                    cmd_take,
  output logic                    empty,
  input  wire logic               pop,
  output chkv_pkg::out_item_t     out_item
);
  localparam int LW = chkv_pkg::LW;
  localparam int IW = chkv_pkg::IW;

  typedef enum logic [2:0] {S_IDLE, S_HEAD, S_READ, S_FETCH, S_CMP, S_DONE} state_t;

  logic [LW-1:0] head_mem [chkv_pkg::NUM_BUCKETS];
  logic [chkv_pkg::NUM_BUCKETS-1:0] head_ok;
  logic [31:0]   key_mem  [chkv_pkg::POOL_ENTRIES];
  logic [31:0]   val_mem  [chkv_pkg::POOL_ENTRIES];
  logic [LW-1:0] link_mem [chkv_pkg::POOL_ENTRIES];

  state_t         state;
  chkv_pkg::cmd_t c;
  logic [LW-1:0]  cur, prev, used;
  logic [31:0]    rd_key, rd_val;
  logic [LW-1:0]  rd_link, head_rd;
  logic           out_full;
  logic [LW-1:0]  n_link;
  logic           finish;

  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign empty    = !out_full;
  assign finish   = (state == S_CMP) && (cur == chkv_pkg::NIL || rd_key >= c.item.key)
                    && (!out_full || pop);

  always_ff @(posedge clk) begin
    head_rd <= head_ok[c.bucket] ? head_mem[c.bucket] : chkv_pkg::NIL;
    rd_key  <= key_mem[cur[IW-1:0]];
    rd_val  <= val_mem[cur[IW-1:0]];
    rd_link <= link_mem[cur[IW-1:0]];
  end

  always_comb n_link = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
      used     <= '0;
      head_ok  <= '0;
    end else begin
      if (finish) out_full <= 1'b1;
      else if (pop && out_full) out_full <= 1'b0;
      case (state)
        S_IDLE: if (cmd_take) begin
          c     <= cmd;
          prev  <= chkv_pkg::NIL;
          state <= S_HEAD;
        end
        S_HEAD: state <= S_READ;
        S_READ: begin
          cur   <= head_rd;
          state <= S_FETCH;
        end
        S_FETCH: state <= S_CMP;
        S_CMP: begin
          if (cur == chkv_pkg::NIL || rd_key >= c.item.key) begin
            if (finish) begin
              out_item.found      <= (cur != chkv_pkg::NIL) && rd_key == c.item.key;
              out_item.read_value <= '0;
              out_item.status     <= 1'b0;
              if (cur != chkv_pkg::NIL && rd_key == c.item.key) begin
                if (c.item.func == chkv_pkg::FUNC_LOOKUP)
                  out_item.read_value <= rd_val;
                else
                  val_mem[cur[IW-1:0]] <= c.item.value;
              end else if (c.item.func == chkv_pkg::FUNC_INSERT) begin
                if (used >= chkv_pkg::NIL) begin
                  out_item.status <= 1'b1;
                end else begin
                  key_mem[used[IW-1:0]]  <= c.item.key;
                  val_mem[used[IW-1:0]]  <= c.item.value;
                  link_mem[used[IW-1:0]] <= n_link;
                  if (prev == chkv_pkg::NIL) begin
                    head_mem[c.bucket] <= used;
                    head_ok[c.bucket]  <= 1'b1;
                  end else begin
                    link_mem[prev[IW-1:0]] <= used;
                  end
                  used <= used + LW'(1);
                end
              end
              state <= S_DONE;
            end
          end else begin
            prev  <= cur;
            cur   <= rd_link;
            state <= S_FETCH;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ tb/chained_hash_key_value_map_tb.sv @@
// Testbench for the chained hash key/value map: random and directed items checked against a model.
`default_nettype none
module chained_hash_key_value_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  int errors = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  class kv_scoreboard;
    logic [31:0]         table_value [logic [31:0]];
    int                  used;
    chkv_pkg::out_item_t pending [$];

    function void note_item(chkv_pkg::in_item_t it);
      chkv_pkg::out_item_t r;
      r = '0;
      if (table_value.exists(it.key)) begin
        r.found = 1'b1;
        if (it.func == chkv_pkg::FUNC_LOOKUP) r.read_value = table_value[it.key];
        else table_value[it.key] = it.value;
      end else if (it.func == chkv_pkg::FUNC_INSERT) begin
        if (used >= chkv_pkg::POOL_ENTRIES) begin
          r.status = 1'b1;
        end else begin
          table_value[it.key] = it.value;
          used++;
        end
      end
      pending.push_back(r);
    endfunction

    task check_result(chkv_pkg::out_item_t got);
      chkv_pkg::out_item_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 32'd0, 32'd0);
        return;
      end
      want = pending.pop_front();
      if (got.found !== want.found) report("found", 32'(got.found), 32'(want.found));
      if (got.read_value !== want.read_value)
        report("read_value", got.read_value, want.read_value);
      if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
    endtask
  endclass

  logic clk = 0, rst = 1, push = 0, pop = 0, full, empty;
  chkv_pkg::in_item_t in_item = '0;
  chkv_pkg::out_item_t out_item;
  kv_scoreboard sb = new();
  bit calm = 0, hold_rx = 0, tx_done = 0;
  logic [31:0] keys_seen [$];

  always #5 clk = ~clk;

  chained_hash_key_value_map dut (.*);

  always @(posedge clk) begin
    if (!rst && push && !full) sb.note_item(in_item);
    if (!rst && pop && !empty) sb.check_result(out_item);
  end

  task automatic send(input logic func, input logic [31:0] key, input logic [31:0] value);
    int g;
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 0;
      g = $urandom_range(1, 9);
      repeat (g) @(negedge clk);
    end
    push <= 1;
    in_item <= '{func: func, key: key, value: value};
    keys_seen.push_back(key);
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    if (keys_seen.size() > 0 && $urandom_range(0, 1))
      return keys_seen[$urandom_range(0, keys_seen.size() - 1)];
    case ($urandom_range(0, 2))
      0: return $urandom();
      1: return $urandom_range(0, 40) * chkv_pkg::NUM_BUCKETS + $urandom_range(0, 3);
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  // receiver
  initial begin
    int g;
    @(negedge clk);
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        pop <= 0;
        repeat (300) @(negedge clk);
        hold_rx = 0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        pop <= 0;
        g = $urandom_range(1, 9);
        repeat (g - 1) @(negedge clk);
      end else begin
        pop <= 1;
      end
    end
  end

  initial begin
    logic [31:0] k;
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    send(chkv_pkg::FUNC_LOOKUP, 32'd0, 32'hFFFF_FFFF);
    send(chkv_pkg::FUNC_INSERT, 32'd0, 32'hFFFF_FFFF);
    send(chkv_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 32'd0);
    send(chkv_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h1234);
    send(chkv_pkg::FUNC_INSERT, 32'd128, 32'hA5A5_5A5A);
    send(chkv_pkg::FUNC_INSERT, 32'd64, 32'h5A5A_A5A5);
    send(chkv_pkg::FUNC_INSERT, 32'd192, 32'h1);
    send(chkv_pkg::FUNC_LOOKUP, 32'd64, 32'h0);
    send(chkv_pkg::FUNC_LOOKUP, 32'd96, 32'h0);
    send(chkv_pkg::FUNC_LOOKUP, 32'd256, 32'h0);
    send(chkv_pkg::FUNC_INSERT, 32'd64, 32'hDEAD_BEEF);
    send(chkv_pkg::FUNC_LOOKUP, 32'd64, 32'h0);
    send(chkv_pkg::FUNC_LOOKUP, 32'd0, 32'h0);
    hold_rx = 1;
    for (int i = 0; i < 20; i++) send(1'($urandom_range(0, 1)), pick_key(), $urandom());
    for (int i = 0; i < 190; i++) begin
      k = pick_key();
      send($urandom_range(0, 2) == 0, k, $urandom());
    end
    // fill the pool, then exercise refused inserts and updates
    while (sb.used < chkv_pkg::POOL_ENTRIES)
      send(chkv_pkg::FUNC_INSERT, $urandom(), $urandom());
    calm = 1;
    for (int i = 0; i < 30; i++) send($urandom_range(0, 2) == 0, pick_key(), $urandom());
    push <= 0;
    tx_done = 1;
  end

  initial begin
    wait (tx_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
